[rtl/owring_pkg.sv]
package owring_pkg;

    // Status codes of a result item.
    localparam logic [2:0] STATUS_RECORD      = 3'd0;
    localparam logic [2:0] STATUS_DRAIN_EMPTY = 3'd1;
    localparam logic [2:0] STATUS_STORED      = 3'd2;
    localparam logic [2:0] STATUS_DISCARDED   = 3'd3;
    localparam logic [2:0] STATUS_NOT_READY   = 3'd4;

    // Operation codes of an input item.
    localparam logic OP_REPORT = 1'b0;
    localparam logic OP_DRAIN  = 1'b1;

    // A drain never returns more results than this.
    localparam int RESULT_LIMIT = 16;

    typedef struct packed {
        logic        op;
        logic [63:0] timestamp;
        logic [31:0] process_id;
        logic [31:0] thread_id;
        logic [31:0] severity;
        logic [31:0] category;
        logic [63:0] address;
        logic [63:0] auxiliary;
        logic [4:0]  max_count;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] sequence_res;
        logic [63:0] rec_time;
        logic [31:0] rec_process;
        logic [31:0] rec_thread;
        logic [31:0] rec_severity;
        logic [31:0] rec_category;
        logic [63:0] rec_address;
        logic [63:0] rec_auxiliary;
        logic [9:0]  remaining;
        logic [63:0] dropped_total;
        logic        last;
    } out_item_t;

    // One stored record, as it sits in the record memory.
    typedef struct packed {
        logic [63:0] rec_time;
        logic [63:0] rec_seq;
        logic [31:0] rec_process;
        logic [31:0] rec_thread;
        logic [31:0] rec_severity;
        logic [31:0] rec_category;
        logic [63:0] rec_address;
        logic [63:0] rec_auxiliary;
    } record_t;

endpackage

[rtl/owring_ram.sv]
module owring_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/overwrite_oldest_event_ring_top.sv]
// Report: the result is registered and comes in the cycle after the item is accepted; busy
// stays low, so a report can be accepted in every cycle in which no config write is given.
// Drain of n records (n up to MAX_PER_DRAIN, at most 16): busy is high while the drain runs,
// one record is read per cycle through the single read port of the record memory, and the
// results follow one per cycle, each registered from its memory read. Empty or disabled
// drains answer with a single registered result. The receiver cannot stall. Reset clears the
// enable, pointers and counters; the record memory is not cleared.
module overwrite_oldest_event_ring_top #(
    parameter int RING_DEPTH    = 512,
    parameter int MAX_PER_DRAIN = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  owring_pkg::in_item_t  item,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_wr_data,
    output logic                  result_valid,
    output owring_pkg::out_item_t result
);

    import owring_pkg::*;

    localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FW = $clog2(RING_DEPTH + 1);
    localparam int CW = (FW > 5) ? FW : 5;
    localparam int DRAIN_LIMIT = (MAX_PER_DRAIN < RESULT_LIMIT) ? MAX_PER_DRAIN : RESULT_LIMIT;
    localparam logic [PW-1:0] LAST_SLOT  = PW'(RING_DEPTH - 1);
    localparam logic [FW-1:0] FULL_COUNT = FW'(RING_DEPTH);
    localparam logic [4:0]    LIMIT_CNT  = 5'(DRAIN_LIMIT);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_DRAIN = 2'b10
    } state_t;

    state_t        state_reg, state_next;
    logic          enabled_reg, enabled_next;
    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [63:0]   seq_cnt_reg, seq_cnt_next;
    logic [63:0]   drop_cnt_reg, drop_cnt_next;
    logic [4:0]    cnt_reg, cnt_next;

    logic          res_valid_reg, res_valid_next;
    logic          res_rec_reg, res_rec_next;
    logic [2:0]    res_status_reg, res_status_next;
    logic [63:0]   res_seq_reg, res_seq_next;
    logic [FW-1:0] res_remaining_reg, res_remaining_next;
    logic [63:0]   res_dropped_reg, res_dropped_next;
    logic          res_last_reg, res_last_next;

    logic          ram_we;
    logic          ram_re;
    record_t       ram_wdata;
    record_t       ram_rdata;

    logic          accept;
    logic          full;
    logic [4:0]    want;
    logic [CW-1:0] want_ext;
    logic [CW-1:0] fill_ext;
    logic [4:0]    take;
    logic [PW-1:0] head_inc;
    logic [PW-1:0] tail_inc;

    owring_ram #(
        .WIDTH ($bits(record_t)),
        .DEPTH (RING_DEPTH)
    ) u_record_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    assign busy     = (state_reg == S_DRAIN);
    assign accept   = start && (state_reg == S_IDLE);
    assign full     = (fill_reg == FULL_COUNT);
    assign head_inc = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == LAST_SLOT) ? '0 : tail_reg + 1'b1;

    assign want     = (item.max_count > LIMIT_CNT) ? LIMIT_CNT : item.max_count;
    assign want_ext = CW'(want);
    assign fill_ext = CW'(fill_reg);
    assign take     = (want_ext < fill_ext) ? want : 5'(fill_reg);

    always_comb
    begin
        ram_wdata.rec_time      = item.timestamp;
        ram_wdata.rec_seq       = seq_cnt_reg + 64'd1;
        ram_wdata.rec_process   = item.process_id;
        ram_wdata.rec_thread    = item.thread_id;
        ram_wdata.rec_severity  = item.severity;
        ram_wdata.rec_category  = item.category;
        ram_wdata.rec_address   = item.address;
        ram_wdata.rec_auxiliary = item.auxiliary;
    end

    always_comb
    begin
        state_next         = state_reg;
        enabled_next       = enabled_reg;
        head_next          = head_reg;
        tail_next          = tail_reg;
        fill_next          = fill_reg;
        seq_cnt_next       = seq_cnt_reg;
        drop_cnt_next      = drop_cnt_reg;
        cnt_next           = cnt_reg;
        res_valid_next     = 1'b0;
        res_rec_next       = 1'b0;
        res_status_next    = res_status_reg;
        res_seq_next       = res_seq_reg;
        res_remaining_next = res_remaining_reg;
        res_dropped_next   = res_dropped_reg;
        res_last_next      = res_last_reg;
        ram_we             = 1'b0;
        ram_re             = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cfg_wr_en)
                begin
                    if (cfg_wr_data != enabled_reg)
                    begin
                        enabled_next = cfg_wr_data;
                        head_next    = '0;
                        tail_next    = '0;
                        fill_next    = '0;
                        if (cfg_wr_data)
                        begin
                            seq_cnt_next  = '0;
                            drop_cnt_next = '0;
                        end
                    end
                end
                else if (accept)
                begin
                    res_valid_next = 1'b1;
                    res_last_next  = 1'b1;
                    if (!enabled_reg)
                    begin
                        res_status_next    = (item.op == OP_REPORT) ? STATUS_DISCARDED
                                                                    : STATUS_NOT_READY;
                        res_seq_next       = seq_cnt_reg;
                        res_remaining_next = fill_reg;
                        res_dropped_next   = drop_cnt_reg;
                    end
                    else if (item.op == OP_REPORT)
                    begin
                        // A full ring writes over its oldest record, which sits at the tail.
                        ram_we       = 1'b1;
                        tail_next    = tail_inc;
                        seq_cnt_next = seq_cnt_reg + 64'd1;
                        if (full)
                        begin
                            head_next     = head_inc;
                            drop_cnt_next = drop_cnt_reg + 64'd1;
                        end
                        else
                        begin
                            fill_next = fill_reg + 1'b1;
                        end
                        res_status_next    = STATUS_STORED;
                        res_seq_next       = seq_cnt_next;
                        res_remaining_next = fill_next;
                        res_dropped_next   = drop_cnt_next;
                    end
                    else if (take == 5'd0)
                    begin
                        res_status_next    = STATUS_DRAIN_EMPTY;
                        res_seq_next       = seq_cnt_reg;
                        res_remaining_next = fill_reg;
                        res_dropped_next   = drop_cnt_reg;
                    end
                    else
                    begin
                        res_valid_next = 1'b0;
                        cnt_next       = take;
                        state_next     = S_DRAIN;
                    end
                end
            end
            S_DRAIN:
            begin
                // The record read here is presented in the next cycle.
                ram_re             = 1'b1;
                head_next          = head_inc;
                fill_next          = fill_reg - 1'b1;
                cnt_next           = cnt_reg - 1'b1;
                res_valid_next     = 1'b1;
                res_rec_next       = 1'b1;
                res_status_next    = STATUS_RECORD;
                res_remaining_next = fill_next;
                res_dropped_next   = drop_cnt_reg;
                res_last_next      = (cnt_reg == 5'd1);
                if (cnt_reg == 5'd1)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            enabled_reg   <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            seq_cnt_reg   <= '0;
            drop_cnt_reg  <= '0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
            res_rec_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            enabled_reg   <= enabled_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            seq_cnt_reg   <= seq_cnt_next;
            drop_cnt_reg  <= drop_cnt_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
            res_rec_reg   <= res_rec_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_status_reg    <= res_status_next;
        res_seq_reg       <= res_seq_next;
        res_remaining_reg <= res_remaining_next;
        res_dropped_reg   <= res_dropped_next;
        res_last_reg      <= res_last_next;
    end

    always_comb
    begin
        result.status        = res_status_reg;
        result.sequence_res  = res_rec_reg ? ram_rdata.rec_seq : res_seq_reg;
        result.rec_time      = res_rec_reg ? ram_rdata.rec_time : '0;
        result.rec_process   = res_rec_reg ? ram_rdata.rec_process : '0;
        result.rec_thread    = res_rec_reg ? ram_rdata.rec_thread : '0;
        result.rec_severity  = res_rec_reg ? ram_rdata.rec_severity : '0;
        result.rec_category  = res_rec_reg ? ram_rdata.rec_category : '0;
        result.rec_address   = res_rec_reg ? ram_rdata.rec_address : '0;
        result.rec_auxiliary = res_rec_reg ? ram_rdata.rec_auxiliary : '0;
        result.remaining     = 10'(res_remaining_reg);
        result.dropped_total = res_dropped_reg;
        result.last          = res_last_reg;
    end

    assign result_valid = res_valid_reg;

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FULL_COUNT)
        else $error("fill count above ring depth");

    a_drain_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN) |-> (cnt_reg != 5'd0 && fill_reg != '0))
        else $error("drain running with nothing to read");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("record memory read and written in one cycle");

    a_drain_ends_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN && cnt_reg == 5'd1) |=> (result_valid && result.last))
        else $error("final drain record not marked last");

endmodule
